### hdl/qwdds_pkg.sv
package qwdds_pkg;

	localparam int PHASE_W     = 32;
	localparam int SAMPLE_W    = 16;
	localparam int MAG_W       = 15;
	localparam int SCALE_W     = 16;
	localparam int CFG_W       = 32;
	localparam int FRAC_BITS   = 15;
	localparam int QUEUE_DEPTH = 8;

	localparam logic [MAG_W-1:0]   MAG_MAX     = 15'h7fff;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'h8000;
	localparam logic [63:0]        PI_Q60      = 64'h3243_f6a8_885a_308d;

	typedef enum logic [0:0] {
		CFG_PHASE_STEP      = 1'b0,
		CFG_AMPLITUDE_SCALE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sine;
		logic signed [SAMPLE_W-1:0] cosine;
	} sample_t;

	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[123:60];
	endfunction

	// round(32768 * sin((i + 0.5) * pi / 2^(addr_bits + 1))), clamped
	function automatic logic [MAG_W-1:0] rom_entry(int unsigned addr_bits, int unsigned i);
		logic [63:0] unit;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] v;
		unit = PI_Q60 >> (addr_bits + 2);
		x    = unit * 64'(2 * i + 1);
		x2   = mul_q60(x, x);
		term = x;
		pos  = '0;
		neg  = '0;
		for (int k = 0; k < 24; k++) begin
			if (term != 64'd0) begin
				if ((k % 2) == 1) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
				term = mul_q60(term, x2) / 64'((2 * k + 2) * (2 * k + 3));
			end
		end
		v = pos - neg;
		v = (v + (64'd1 << 44)) >> 45;
		if (v > 64'(MAG_MAX)) begin
			v = 64'(MAG_MAX);
		end
		return v[MAG_W-1:0];
	endfunction

endpackage

### hdl/qwdds_if.sv
interface qwdds_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                load_phase;
	logic [qwdds_pkg::PHASE_W-1:0]        new_phase;
	logic signed [qwdds_pkg::PHASE_W-1:0] phase_mod;
	logic                                advance;

	modport source (output valid, output load_phase, output new_phase,
		output phase_mod, output advance, input ready);
	modport sink (input valid, input load_phase, input new_phase,
		input phase_mod, input advance, output ready);
endinterface

interface qwdds_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [qwdds_pkg::SAMPLE_W-1:0] sine_out;
	logic signed [qwdds_pkg::SAMPLE_W-1:0] cosine_out;

	modport source (output valid, output sine_out, output cosine_out, input ready);
	modport sink (input valid, input sine_out, input cosine_out, output ready);
endinterface

### hdl/qwdds_rom.sv
module qwdds_rom #(
	parameter int ADDR_BITS = 7
) (
	input  logic                        clk,
	input  logic [ADDR_BITS-1:0]        addr_a,
	input  logic [ADDR_BITS-1:0]        addr_b,
	output logic [qwdds_pkg::MAG_W-1:0] data_a,
	output logic [qwdds_pkg::MAG_W-1:0] data_b
);
	import qwdds_pkg::*;

	localparam int SIZE = 1 << ADDR_BITS;

	logic [MAG_W-1:0] tbl [SIZE];
	logic [MAG_W-1:0] data_a_q;
	logic [MAG_W-1:0] data_b_q;

	for (genvar g = 0; g < SIZE; g++) begin : g_entry
		localparam logic [MAG_W-1:0] VALUE = rom_entry(ADDR_BITS, g);
		assign tbl[g] = VALUE;
	end

	always_ff @(posedge clk) begin
		data_a_q <= tbl[addr_a];
		data_b_q <= tbl[addr_b];
	end

	assign data_a = data_a_q;
	assign data_b = data_b_q;

endmodule

### hdl/qwdds_scale.sv
module qwdds_scale (
	input  logic                                 clk,
	input  logic [qwdds_pkg::MAG_W-1:0]           mag,
	input  logic                                 neg,
	input  logic [qwdds_pkg::SCALE_W-1:0]         scale,
	output logic signed [qwdds_pkg::SAMPLE_W-1:0] result
);
	import qwdds_pkg::*;

	localparam int PROD_W = MAG_W + SCALE_W;

	logic [PROD_W-1:0]        prod_s3;
	logic                     neg_s3;
	logic [PROD_W:0]          biased;
	logic [PROD_W-FRAC_BITS:0] mag_r;
	logic [MAG_W-1:0]         mag_sat;
	logic [SAMPLE_W-1:0]      pos_val;

	always_ff @(posedge clk) begin
		prod_s3 <= {{SCALE_W{1'b0}}, mag} * {{MAG_W{1'b0}}, scale};
		neg_s3  <= neg;
	end

	// floor on the signed value: round the magnitude up when negative
	always_comb begin
		biased  = neg_s3 ? ({1'b0, prod_s3} + (PROD_W+1)'(MAG_MAX)) : {1'b0, prod_s3};
		mag_r   = biased[PROD_W:FRAC_BITS];
		mag_sat = (mag_r > (PROD_W-FRAC_BITS+1)'(MAG_MAX)) ? MAG_MAX : mag_r[MAG_W-1:0];
		pos_val = {1'b0, mag_sat};
		result  = $signed(neg_s3 ? (~pos_val + SAMPLE_W'(1)) : pos_val);
	end

endmodule

### hdl/qwdds_resq.sv
module qwdds_resq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               push,
	input  qwdds_pkg::sample_t push_data,
	output logic               room,
	qwdds_sample_if.source     sample
);
	import qwdds_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sample_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] occ_q;
	logic             pop;
	sample_t          head;

	assign pop  = sample.valid && sample.ready;
	assign room = occ_q < CNT_W'(QUEUE_DEPTH);
	assign head = mem_q[rd_ptr_q];

	assign sample.valid      = fill_q != '0;
	assign sample.sine_out   = head.sine;
	assign sample.cosine_out = head.cosine;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + CNT_W'(push) - CNT_W'(pop);
			occ_q  <= occ_q + CNT_W'(take) - CNT_W'(pop);
		end
	end

endmodule

### hdl/quarter_wave_dds_oscillator.sv
// Sine/cosine oscillator: one item in, one sample pair out. The block takes an
// item every clock while ready is high and delivers its sine and cosine after
// acceptance through the accumulator add, registered quarter-wave ROM read on
// two ports, multiply by amplitude_scale, and round and saturate into an
// eight-entry result queue. Ready stays high while fewer than eight items are
// accepted and not yet taken, so a sink that always takes keeps the rate at one
// item per clock; a stalled sink fills the queue and then holds ready low. The
// ROM holds 2^TABLE_ADDR_BITS entries and is built at elaboration.
module quarter_wave_dds_oscillator #(
	parameter int TABLE_ADDR_BITS = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	qwdds_cmd_if.sink                   phase_cmd,
	qwdds_sample_if.source              sample,
	input  logic                        cfg_we,
	input  qwdds_pkg::cfg_reg_t         cfg_idx,
	input  logic [qwdds_pkg::CFG_W-1:0] cfg_wdata
);
	import qwdds_pkg::*;

	localparam int TOP_W = TABLE_ADDR_BITS + 2;

	logic [PHASE_W-1:0]         acc_q;
	logic [PHASE_W-1:0]         step_q;
	logic [SCALE_W-1:0]         scale_q;
	logic                       in_acc;
	logic                       room;
	logic [PHASE_W-1:0]         base;
	logic [PHASE_W-1:0]         phase;

	logic                       v_s1;
	logic [TOP_W-1:0]           ptop_s1;
	logic [1:0]                 quad_sin;
	logic [1:0]                 quad_cos;
	logic [TABLE_ADDR_BITS-1:0] low;
	logic [TABLE_ADDR_BITS-1:0] idx_sin;
	logic [TABLE_ADDR_BITS-1:0] idx_cos;

	logic                       v_s2;
	logic                       neg_sin_s2;
	logic                       neg_cos_s2;
	logic [MAG_W-1:0]           mag_sin;
	logic [MAG_W-1:0]           mag_cos;

	logic                       v_s3;
	logic signed [SAMPLE_W-1:0] sin_res;
	logic signed [SAMPLE_W-1:0] cos_res;
	sample_t                    push_data;

	assign in_acc          = phase_cmd.valid && phase_cmd.ready;
	assign phase_cmd.ready = room;

	assign base  = phase_cmd.load_phase ? phase_cmd.new_phase : acc_q;
	assign phase = base + $unsigned(phase_cmd.phase_mod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			step_q  <= '0;
			scale_q <= SCALE_RESET;
		end else begin
			if (in_acc) begin
				acc_q <= phase_cmd.advance ? base + step_q : base;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_PHASE_STEP:      step_q  <= cfg_wdata;
					CFG_AMPLITUDE_SCALE: scale_q <= cfg_wdata[SCALE_W-1:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ptop_s1    <= phase[PHASE_W-1 -: TOP_W];
		neg_sin_s2 <= quad_sin[1];
		neg_cos_s2 <= quad_cos[1];
	end

	// cosine is a quarter turn ahead: same low bits, next quadrant
	always_comb begin
		quad_sin = ptop_s1[TOP_W-1 -: 2];
		quad_cos = quad_sin + 2'd1;
		low      = ptop_s1[TABLE_ADDR_BITS-1:0];
		idx_sin  = quad_sin[0] ? ~low : low;
		idx_cos  = quad_cos[0] ? ~low : low;
	end

	qwdds_rom #(
		.ADDR_BITS(TABLE_ADDR_BITS)
	) u_rom (
		.clk    (clk),
		.addr_a (idx_sin),
		.addr_b (idx_cos),
		.data_a (mag_sin),
		.data_b (mag_cos)
	);

	qwdds_scale u_scale_sin (
		.clk    (clk),
		.mag    (mag_sin),
		.neg    (neg_sin_s2),
		.scale  (scale_q),
		.result (sin_res)
	);

	qwdds_scale u_scale_cos (
		.clk    (clk),
		.mag    (mag_cos),
		.neg    (neg_cos_s2),
		.scale  (scale_q),
		.result (cos_res)
	);

	assign push_data = '{sine: sin_res, cosine: cos_res};

	qwdds_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_acc),
		.push      (v_s3),
		.push_data (push_data),
		.room      (room),
		.sample    (sample)
	);

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1 ##1 v_s2 ##1 v_s3)
		else $error("accepted item lost in the lookup pipeline");

	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> acc_q == $past(acc_q))
		else $error("accumulator changed without an accepted item");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !phase_cmd.load_phase && !phase_cmd.advance |=> acc_q == $past(acc_q))
		else $error("accumulator moved on an item without load or advance");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $past(v_s2))
		else $error("result pushed without a lookup in flight");

endmodule
